@@ rtl/core/hlfs_pkg.sv @@
// Package with shared types, constants and the saturating add and row seed functions of the flow sketch.
`default_nettype none
package hlfs_pkg;

  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] START_REWARD = 32'd4;
  localparam logic [10:0] OCC_MAX      = 11'd2047;
  localparam logic [31:0] MIX_MULT     = 32'h045d_9f3b;
  localparam logic [31:0] FMIX_MULT_A  = 32'h85eb_ca6b;
  localparam logic [31:0] FMIX_MULT_B  = 32'hc2b2_ae35;
  localparam logic [31:0] SEED_0       = 32'h9747_b28c;
  localparam logic [31:0] SEED_1       = 32'h85eb_ca6b;
  localparam logic [31:0] SEED_2       = 32'hc2b2_ae35;
  localparam logic [31:0] SEED_3       = 32'h27d4_eb2f;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] flow_id;
  } in_word_t;

  typedef struct packed {
    logic [31:0] estimate;
    logic        from_heavy;
    logic        evicted;
    logic [10:0] active_buckets;
    logic [31:0] eviction_total;
  } out_word_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] count;
    logic [31:0] reward;
  } slot_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic clear_step;
    logic hash_a;
    logic hash_b;
    logic hash_c;
    logic mix_a;
    logic mix_b;
    logic heavy_eval;
    logic sketch_cmp;
    logic sketch_write;
    logic next_row;
    logic pick_new;
    logic finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic is_query;
    logic need_evict;
    logic need_sketch_query;
    logic last_row;
    logic second_id;
  } status_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ALL_ONES : s[31:0];
  endfunction

  function automatic logic [31:0] row_seed(input logic [1:0] r);
    logic [31:0] s;
    case (r)
      2'd0:    s = SEED_0;
      2'd1:    s = SEED_1;
      2'd2:    s = SEED_2;
      default: s = SEED_3;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/hlfs_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module hlfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/hlfs_datapath.sv @@
// Datapath of the flow sketch: hashes, heavy table, sketch rows and counters.
`default_nettype none
module hlfs_datapath #(
  parameter int HEAVY_BUCKETS = 1024,
  parameter int SKETCH_ROWS   = 4,
  parameter int SKETCH_COLS   = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hlfs_pkg::in_word_t in_word,
  input  wire hlfs_pkg::cmd_t     cmd,
  output hlfs_pkg::status_t       status,
  output hlfs_pkg::out_word_t     out_word
);

  localparam int HB_W  = $clog2(HEAVY_BUCKETS);
  localparam int COL_W = $clog2(SKETCH_COLS);
  localparam int ROW_W = (SKETCH_ROWS > 1) ? $clog2(SKETCH_ROWS) : 1;
  localparam int SK_DEPTH = SKETCH_ROWS * SKETCH_COLS;
  localparam int SK_W  = $clog2(SK_DEPTH);
  localparam int CLR_LEN = (SK_DEPTH > HEAVY_BUCKETS) ? SK_DEPTH : HEAVY_BUCKETS;
  localparam int CLR_W = $clog2(CLR_LEN) + 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SKETCH_ROWS - 1);

  logic              kind;
  logic [31:0]       flow_id;
  logic [31:0]       hash;
  logic [31:0]       mult_in;
  logic [31:0]       mult_out;
  logic [HB_W-1:0]   bucket;
  logic [ROW_W-1:0]  row;
  logic              second_id;
  logic [31:0]       evict_id;
  logic [31:0]       evict_count;
  logic [31:0]       minimum;
  logic [COL_W-1:0]  col;
  logic [CLR_W-1:0]  clr_idx;
  logic              clearing;
  logic              need_evict;
  logic              need_sk;
  logic              evicted;
  logic              from_heavy;
  logic [31:0]       estimate;
  logic [10:0]       occupied;
  logic [31:0]       evictions;

  hlfs_pkg::slot_t slot_rd;
  hlfs_pkg::slot_t slot_wr;
  logic            heavy_we;
  logic [HB_W-1:0] heavy_addr;
  logic [31:0]     sk_rd;
  logic [31:0]     sk_wr;
  logic            sk_we;
  logic [SK_W-1:0] sk_addr;
  logic [31:0]     sk_amount;
  logic [31:0]     key_id;

  hlfs_ram #(.WIDTH(96), .DEPTH(HEAVY_BUCKETS)) u_heavy (
    .clk(clk), .we(heavy_we), .addr(heavy_addr), .wdata(slot_wr), .rdata(slot_rd)
  );

  hlfs_ram #(.WIDTH(32), .DEPTH(SK_DEPTH)) u_sketch (
    .clk(clk), .we(sk_we), .addr(sk_addr), .wdata(sk_wr), .rdata(sk_rd)
  );

  assign key_id = second_id ? flow_id : evict_id;

  // One shared multiplier; the register after it is hash.
  always_comb begin
    mult_in  = 32'd0;
    mult_out = 32'd0;
    if (cmd.hash_a || cmd.hash_b) begin
      mult_in  = (hash >> 16) ^ hash;
      mult_out = mult_in * hlfs_pkg::MIX_MULT;
    end else if (cmd.mix_a) begin
      mult_in  = (key_id ^ hlfs_pkg::row_seed(2'(row))) ^
                 ((key_id ^ hlfs_pkg::row_seed(2'(row))) >> 16);
      mult_out = mult_in * hlfs_pkg::FMIX_MULT_A;
    end else if (cmd.mix_b) begin
      mult_in  = hash ^ (hash >> 13);
      mult_out = mult_in * hlfs_pkg::FMIX_MULT_B;
    end
  end

  assign col = COL_W'(hash ^ (hash >> 16));
  assign sk_addr = clearing ? SK_W'(clr_idx) :
                   SK_W'({row, col} & {ROW_W + COL_W{1'b1}});
  assign heavy_addr = clearing ? HB_W'(clr_idx) : bucket;

  always_comb begin
    logic [31:0] dec;
    dec = (slot_rd.reward != 32'd0) ? slot_rd.reward - 32'd1 : 32'd0;
    slot_wr    = slot_rd;
    heavy_we   = 1'b0;
    need_evict = 1'b0;
    need_sk    = 1'b0;
    if (clearing) begin
      slot_wr  = '0;
      heavy_we = 1'b1;
    end else if (cmd.heavy_eval) begin
      if (kind == hlfs_pkg::KIND_INSERT) begin
        heavy_we = 1'b1;
        if (slot_rd.count == 32'd0) begin
          slot_wr = '{id: flow_id, count: 32'd1, reward: hlfs_pkg::START_REWARD};
        end else if (slot_rd.id == flow_id) begin
          slot_wr.count  = hlfs_pkg::sat_inc(slot_rd.count, 32'd1);
          slot_wr.reward = hlfs_pkg::sat_inc(slot_rd.reward, 32'd1);
        end else if (dec != 32'd0) begin
          slot_wr.reward = dec;
        end else begin
          slot_wr = '{id: flow_id, count: 32'd1, reward: hlfs_pkg::START_REWARD};
          need_evict = 1'b1;
        end
      end else begin
        need_sk = !(slot_rd.id == flow_id && slot_rd.count != 32'd0);
      end
    end
  end

  assign sk_amount = second_id ? 32'd1 : evict_count;
  assign sk_wr = clearing ? 32'd0 : hlfs_pkg::sat_inc(sk_rd, sk_amount);
  assign sk_we = clearing || cmd.sketch_write;

  // Reset starts a sweep that walks an index over the entries of the larger memory, clearing both memories.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == CLR_W'(CLR_LEN - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied   <= '0;
      evictions  <= '0;
      evicted    <= 1'b0;
      from_heavy <= 1'b0;
      estimate   <= '0;
    end else begin
      if (cmd.clear_step) begin
        evicted    <= 1'b0;
        from_heavy <= 1'b0;
        estimate   <= '0;
        minimum    <= hlfs_pkg::ALL_ONES;
        row        <= '0;
        second_id  <= 1'b1;
      end
      if (cmd.heavy_eval) begin
        evict_id    <= slot_rd.id;
        evict_count <= slot_rd.count;
        second_id   <= ~need_evict;
        if (kind == hlfs_pkg::KIND_INSERT && slot_rd.count == 32'd0 &&
            occupied < hlfs_pkg::OCC_MAX) begin
          occupied <= occupied + 11'd1;
        end
        if (need_evict) begin
          evicted   <= 1'b1;
          evictions <= hlfs_pkg::sat_inc(evictions, 32'd1);
        end
        if (kind == hlfs_pkg::KIND_QUERY && !need_sk) begin
          estimate   <= slot_rd.count;
          from_heavy <= 1'b1;
        end
      end
      if (cmd.sketch_cmp && sk_rd < minimum) begin
        minimum <= sk_rd;
      end
      if (cmd.next_row) begin
        row <= row + ROW_W'(1);
      end
      if (cmd.pick_new) begin
        row       <= '0;
        second_id <= 1'b1;
      end
      if (cmd.finish && kind == hlfs_pkg::KIND_QUERY && !from_heavy) begin
        estimate <= (minimum == hlfs_pkg::ALL_ONES) ? 32'd0 : minimum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind    <= in_word.kind;
      flow_id <= in_word.flow_id;
      hash    <= in_word.flow_id;
    end
    if (cmd.hash_a || cmd.hash_b || cmd.mix_a || cmd.mix_b) begin
      hash <= mult_out;
    end
    if (cmd.hash_c) begin
      bucket <= HB_W'((hash >> 16) ^ hash);
    end
  end

  assign status.clear_done        = !clearing;
  assign status.is_query          = (kind == hlfs_pkg::KIND_QUERY);
  assign status.need_evict        = need_evict;
  assign status.need_sketch_query = need_sk;
  assign status.last_row          = (row == LAST_ROW);
  assign status.second_id         = second_id;

  assign out_word.estimate       = estimate;
  assign out_word.from_heavy     = from_heavy;
  assign out_word.evicted        = evicted;
  assign out_word.active_buckets = occupied;
  assign out_word.eviction_total = evictions;

endmodule
`default_nettype wire

@@ rtl/core/hlfs_ctrl.sv @@
// Controller state machine that sequences the flow sketch datapath.
`default_nettype none
module hlfs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire hlfs_pkg::status_t status,
  output hlfs_pkg::cmd_t         cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_HA    = 11'b00000000010,
    S_HB    = 11'b00000000100,
    S_HC    = 11'b00000001000,
    S_HRD   = 11'b00000010000,
    S_HEVAL = 11'b00000100000,
    S_MA    = 11'b00001000000,
    S_MB    = 11'b00010000000,
    S_SRD   = 11'b00100000000,
    S_SOP   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   busy_out;

  assign in_stall  = !(state == S_IDLE && status.clear_done && !busy_out);
  assign out_valid = busy_out;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_in    = 1'b1;
          cmd.clear_step = 1'b1;
          state_next = S_HA;
        end
      end
      S_HA: begin
        cmd.hash_a = 1'b1;
        state_next = S_HB;
      end
      S_HB: begin
        cmd.hash_b = 1'b1;
        state_next = S_HC;
      end
      S_HC: begin
        cmd.hash_c = 1'b1;
        state_next = S_HRD;
      end
      S_HRD: begin
        state_next = S_HEVAL;
      end
      S_HEVAL: begin
        cmd.heavy_eval = 1'b1;
        state_next = (status.need_evict || status.need_sketch_query) ? S_MA : S_DONE;
      end
      S_MA: begin
        cmd.mix_a = 1'b1;
        state_next = S_MB;
      end
      S_MB: begin
        cmd.mix_b = 1'b1;
        state_next = S_SRD;
      end
      S_SRD: begin
        state_next = S_SOP;
      end
      S_SOP: begin
        if (status.is_query) begin
          cmd.sketch_cmp = 1'b1;
        end else begin
          cmd.sketch_write = 1'b1;
        end
        if (!status.last_row) begin
          cmd.next_row = 1'b1;
          state_next = S_MA;
        end else if (!status.is_query && !status.second_id) begin
          cmd.pick_new = 1'b1;
          state_next = S_MA;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      busy_out <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE) begin
        busy_out <= 1'b1;
      end else if (busy_out && !out_stall) begin
        busy_out <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/heavy_light_flow_sketch_core.sv @@
// Top level of the heavy/light flow sketch.
// One word is processed at a time: an insert without eviction, or a query answered
// from its heavy bucket, skips the sketch; others visit each sketch row through
// the shared hash multiplier and the single sketch RAM port (a query miss once per
// row, an eviction twice per row, once per id). A stalled result holds off the
// next word. After reset both memories are swept clear, one entry a cycle, over
// the larger of SKETCH_ROWS*SKETCH_COLS and HEAVY_BUCKETS entries, taking no word.
`default_nettype none
module heavy_light_flow_sketch_core #(
  parameter int HEAVY_BUCKETS = 1024,
  parameter int SKETCH_ROWS   = 4,
  parameter int SKETCH_COLS   = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hlfs_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hlfs_pkg::out_word_t      out_data
);

  hlfs_pkg::cmd_t    cmd;
  hlfs_pkg::status_t status;

  hlfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  hlfs_datapath #(
    .HEAVY_BUCKETS(HEAVY_BUCKETS), .SKETCH_ROWS(SKETCH_ROWS), .SKETCH_COLS(SKETCH_COLS)
  ) u_dp (
    .clk(clk), .rst(rst), .in_word(in_data), .cmd(cmd), .status(status),
    .out_word(out_data)
  );

endmodule
`default_nettype wire

@@ rtl/core/hlfs_checker.sv @@
// Port checker for the flow sketch, bound to the top level.
`default_nettype none
module hlfs_port_props (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire hlfs_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result waits");

  a_insert_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.evicted |-> !out_data.from_heavy && out_data.estimate == 32'd0)
    else $error("eviction result carries query fields");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result word appeared right after an accepted word");

endmodule

bind heavy_light_flow_sketch_core hlfs_port_props u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

@@ tb/hlfs_checker.sv @@
// Checker that predicts every result word of the flow sketch core and compares it.
`timescale 1ns / 100ps
module hlfs_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  hlfs_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  hlfs_pkg::out_word_t out_data,
  output int                  errors,
  output int                  pending,
  output int                  evictions_seen,
  output int                  heavy_answers
);

  localparam int BUCKETS = 1024;
  localparam int ROWS    = 4;
  localparam int COLS    = 4096;

  logic [31:0] bucket_id     [BUCKETS];
  logic [31:0] bucket_count  [BUCKETS];
  logic [31:0] bucket_reward [BUCKETS];
  logic [31:0] light_counter [ROWS][COLS];
  logic [31:0] evict_tally;
  logic [10:0] busy_buckets;
  hlfs_pkg::out_word_t awaited_words[$];

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int heavy_index(input logic [31:0] id);
    logic [31:0] h;
    h = id;
    h = ((h >> 16) ^ h) * 32'h045d_9f3b;
    h = ((h >> 16) ^ h) * 32'h045d_9f3b;
    h = (h >> 16) ^ h;
    return int'(h % BUCKETS);
  endfunction

  function automatic int light_column(input logic [31:0] id, input int r);
    logic [31:0] h;
    logic [31:0] s;
    case (r)
      0: s = hlfs_pkg::SEED_0;
      1: s = hlfs_pkg::SEED_1;
      2: s = hlfs_pkg::SEED_2;
      default: s = hlfs_pkg::SEED_3;
    endcase
    h = s ^ id;
    h = h ^ (h >> 16);
    h = h * 32'h85eb_ca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2_ae35;
    h = h ^ (h >> 16);
    return int'(h % COLS);
  endfunction

  function automatic void light_add(input logic [31:0] id, input logic [31:0] amount);
    int c;
    for (int r = 0; r < ROWS; r++) begin
      c = light_column(id, r);
      light_counter[r][c] = add_clamped(light_counter[r][c], amount);
    end
  endfunction

  function automatic hlfs_pkg::out_word_t flow_step(input hlfs_pkg::in_word_t w);
    hlfs_pkg::out_word_t o;
    int b;
    logic [31:0] m;
    o = '0;
    b = heavy_index(w.flow_id);
    if (w.kind == hlfs_pkg::KIND_INSERT) begin
      if (bucket_count[b] == 0) begin
        bucket_id[b] = w.flow_id;
        bucket_count[b] = 1;
        bucket_reward[b] = hlfs_pkg::START_REWARD;
        if (busy_buckets < hlfs_pkg::OCC_MAX) busy_buckets++;
      end else if (bucket_id[b] == w.flow_id) begin
        bucket_count[b] = add_clamped(bucket_count[b], 1);
        bucket_reward[b] = add_clamped(bucket_reward[b], 1);
      end else begin
        if (bucket_reward[b] > 0) bucket_reward[b]--;
        if (bucket_reward[b] == 0) begin
          light_add(bucket_id[b], bucket_count[b]);
          light_add(w.flow_id, 1);
          bucket_id[b] = w.flow_id;
          bucket_count[b] = 1;
          bucket_reward[b] = hlfs_pkg::START_REWARD;
          evict_tally = add_clamped(evict_tally, 1);
          o.evicted = 1'b1;
        end
      end
    end else if (bucket_id[b] == w.flow_id && bucket_count[b] > 0) begin
      o.estimate = bucket_count[b];
      o.from_heavy = 1'b1;
    end else begin
      m = hlfs_pkg::ALL_ONES;
      for (int r = 0; r < ROWS; r++)
        if (light_counter[r][light_column(w.flow_id, r)] < m)
          m = light_counter[r][light_column(w.flow_id, r)];
      o.estimate = (m == hlfs_pkg::ALL_ONES) ? 32'd0 : m;
    end
    o.active_buckets = busy_buckets;
    o.eviction_total = evict_tally;
    return o;
  endfunction

  initial begin
    for (int i = 0; i < BUCKETS; i++) begin
      bucket_id[i] = 0;
      bucket_count[i] = 0;
      bucket_reward[i] = 0;
    end
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++) light_counter[r][c] = 0;
    evict_tally = 0;
    busy_buckets = 0;
    errors = 0;
    evictions_seen = 0;
    heavy_answers = 0;
  end

  assign pending = awaited_words.size();

  always @(posedge clk) begin
    hlfs_pkg::out_word_t want;
    if (!rst && in_valid && !in_stall) awaited_words.push_back(flow_step(in_data));
    if (!rst && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word %h", out_data);
      end else begin
        want = awaited_words.pop_front();
        if (want !== out_data) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: est %h/%h heavy %b/%b evict %b/%b active %0d/%0d total %0d/%0d",
                     want.estimate, out_data.estimate, want.from_heavy, out_data.from_heavy,
                     want.evicted, out_data.evicted, want.active_buckets,
                     out_data.active_buckets, want.eviction_total, out_data.eviction_total);
        end
        if (want.evicted) evictions_seen++;
        if (want.from_heavy) heavy_answers++;
      end
    end
  end

endmodule

@@ tb/tb_heavy_light_flow_sketch_core.sv @@
// Testbench top that drives flow events into the sketch core and reports the verdict.
`timescale 1ns / 100ps
module tb_heavy_light_flow_sketch_core;

  localparam int STALL_LIMIT = 60000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hlfs_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hlfs_pkg::out_word_t out_data;
  int        errors;
  int        pending;
  int        evictions_seen;
  int        heavy_answers;
  logic      jitter = 1'b1;
  int        quiet_cycles = 0;
  int        words_sent = 0;
  logic [31:0] rival_ids[24];
  logic [31:0] hot_ids[30];

  heavy_light_flow_sketch_core uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  hlfs_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending), .evictions_seen(evictions_seen),
    .heavy_answers(heavy_answers)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= jitter && ($urandom_range(99) < 20);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic kind, input logic [31:0] id);
    while (jitter && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: kind, flow_id: id};
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] cand;
    int target;
    int pick;
    logic kind;
    for (int g = 0; g < 6; g++) begin
      rival_ids[g * 4] = $urandom;
      target = chk.heavy_index(rival_ids[g * 4]);
      for (int k = 1; k < 4; k++) begin
        do cand = $urandom; while (chk.heavy_index(cand) != target);
        rival_ids[g * 4 + k] = cand;
      end
    end
    foreach (hot_ids[i]) hot_ids[i] = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_word(hlfs_pkg::KIND_QUERY, 32'h0000_0000);
    send_word(hlfs_pkg::KIND_INSERT, 32'h0000_0000);
    send_word(hlfs_pkg::KIND_QUERY, 32'h0000_0000);
    send_word(hlfs_pkg::KIND_INSERT, 32'hFFFF_FFFF);
    send_word(hlfs_pkg::KIND_QUERY, 32'hFFFF_FFFF);
    send_word(hlfs_pkg::KIND_INSERT, 32'hAAAA_AAAA);
    send_word(hlfs_pkg::KIND_INSERT, 32'h5555_5555);
    send_word(hlfs_pkg::KIND_QUERY, 32'h5555_5555);
    send_word(hlfs_pkg::KIND_INSERT, rival_ids[0]);
    send_word(hlfs_pkg::KIND_INSERT, rival_ids[0]);
    repeat (5) send_word(hlfs_pkg::KIND_INSERT, rival_ids[1]);
    send_word(hlfs_pkg::KIND_QUERY, rival_ids[0]);
    send_word(hlfs_pkg::KIND_QUERY, rival_ids[1]);
    send_word(hlfs_pkg::KIND_QUERY, rival_ids[2]);
    send_word(hlfs_pkg::KIND_QUERY, 32'h1234_5678);

    for (int n = 0; n < 550; n++) begin
      jitter = !(n >= 200 && n < 300);
      if (n == 350) drain_results();
      pick = $urandom_range(99);
      kind = ($urandom_range(99) < 35) ? hlfs_pkg::KIND_QUERY : hlfs_pkg::KIND_INSERT;
      if (pick < 70) send_word(kind, rival_ids[$urandom_range(23)]);
      else if (pick < 85) send_word(kind, hot_ids[$urandom_range(29)]);
      else send_word(kind, $urandom);
    end
    drain_results();
    repeat (100) @(posedge clk);

    $display("Sent %0d flow events; %0d evictions and %0d heavy-bucket answers were checked.",
             words_sent, evictions_seen, heavy_answers);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hlfs_pkg.sv
rtl/core/hlfs_ram.sv
rtl/core/hlfs_datapath.sv
rtl/core/hlfs_ctrl.sv
rtl/core/heavy_light_flow_sketch_core.sv
rtl/core/hlfs_checker.sv
tb/hlfs_checker.sv
tb/tb_heavy_light_flow_sketch_core.sv
